// File: rtl/core/rfe_pkg.sv
// ============================================================================
// rfe_pkg - shared types and constants of the RF remote frame encoder
// Field widths, symbol timings, configuration register indexes and the
// structures passed between the front and back halves of the encoder.
// ============================================================================
`default_nettype none

package rfe_pkg;

  // Field widths
  localparam int TX_ID_W      = 26;
  localparam int PERIOD_W     = 16;
  localparam int UNIT_W       = 6;
  localparam int TAIL_BITS    = 6;
  localparam int ID_BITS_DEF  = 26;

  // Low time of each symbol, in base periods
  localparam logic [UNIT_W-1:0] SYNC_LOW_UNITS  = UNIT_W'(10);
  localparam logic [UNIT_W-1:0] PAUSE_LOW_UNITS = UNIT_W'(40);
  localparam logic [UNIT_W-1:0] ONE_LOW_UNITS   = UNIT_W'(1);
  localparam logic [UNIT_W-1:0] ZERO_LOW_UNITS  = UNIT_W'(5);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_BIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_BITS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_BITS      = 2'd3;

  // Reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] TICKS_PER_UNIT_RST = PERIOD_W'(250);
  localparam logic                GROUP_BIT_RST      = 1'b0;
  localparam logic [1:0]          CHANNEL_BITS_RST   = 2'd3;
  localparam logic [1:0]          UNIT_BITS_RST      = 2'd3;

  // Kind of an input item
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_kind_t;

  // One classified item, as held in the command queue
  typedef struct packed {
    cmd_kind_t          kind;
    logic [TX_ID_W-1:0] tx_id;
    logic               on_off;
  } cmd_t;

  // Configuration register file contents
  typedef struct packed {
    logic [PERIOD_W-1:0] ticks_per_unit;
    logic                group_bit;
    logic [1:0]          channel_bits;
    logic [1:0]          unit_bits;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic frame_done;
    logic accepted;
    logic busy_res;
    logic line_level;
  } res_t;

endpackage : rfe_pkg

`default_nettype wire

// File: rtl/core/rfe_front.sv
// ============================================================================
// rfe_front - input side of the RF remote frame encoder
// Accepts stream transactions, classifies each as a start request or a time
// tick and holds it in a two-entry command queue for the back end.
// ============================================================================
`default_nettype none

module rfe_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_mode,
  input  wire logic [rfe_pkg::TX_ID_W-1:0]       in_tx_id,
  input  wire logic                              in_on_off,
  // command queue read side
  output logic                                   cmd_valid,
  input  wire logic                              cmd_ready,
  output rfe_pkg::cmd_t                          cmd
);

  import rfe_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       queue_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;
  logic       push, pop;
  cmd_t       cmd_in;

  // classify the incoming transaction
  always_comb begin
    cmd_in.kind   = in_mode ? CMD_TICK : CMD_START;
    cmd_in.tx_id  = in_tx_id;
    cmd_in.on_off = in_on_off;
  end

  assign in_ready  = (count_r != 2'(DEPTH));
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = queue_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule : rfe_front

`default_nettype wire

// File: rtl/core/rfe_back.sv
// ============================================================================
// rfe_back - frame sequencer of the RF remote frame encoder
// Takes one command a cycle from the queue unless the result is stalled,
// steps the sync / data / pause symbol sequencer and registers the result.
// ============================================================================
`default_nettype none

module rfe_back #(
  parameter int ID_BITS = rfe_pkg::ID_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rfe_pkg::cfg_t  cfg,
  // command queue
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire rfe_pkg::cmd_t  cmd,
  // result stream
  output logic                res_valid,
  input  wire logic           res_ready,
  output rfe_pkg::res_t       res
);

  import rfe_pkg::*;

  localparam int NBITS = ID_BITS + TAIL_BITS;
  localparam int NPHYS = 2 * NBITS;
  localparam int SYM_W = $clog2(NPHYS + 2);
  localparam int KW    = $clog2(NBITS);
  localparam int SEL_N = 1 << KW;

  // one-hot sequencer phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  phase_t               phase_r,  phase_nxt;
  logic [ID_BITS-1:0]   frame_r,  frame_nxt;
  logic [TAIL_BITS-1:0] tail_r,   tail_nxt;
  logic [SYM_W-1:0]     sym_r,    sym_nxt;
  logic [PERIOD_W-1:0]  tick_r,   tick_nxt;
  logic [UNIT_W-1:0]    unit_r,   unit_nxt;
  logic                 res_valid_r, res_valid_nxt;
  res_t                 res_r,    res_nxt;

  logic                 take;
  logic [PERIOD_W-1:0]  period;
  logic [PERIOD_W:0]    tick_sum;
  logic [UNIT_W-1:0]    unit_inc;
  logic [SYM_W-1:0]     phys_idx;
  logic [SYM_W-2:0]     logical_idx;
  logic [SEL_N-1:0]     sel_bits;
  logic                 phys_bit;
  logic [UNIT_W-1:0]    low_units;
  logic [31:0]          id_ext;
  logic                 accepted;
  logic                 done;

  assign take      = cmd_valid && cmd_ready;
  assign cmd_ready = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // low length of the current symbol
  always_comb begin
    phys_idx    = sym_r - SYM_W'(1);
    logical_idx = phys_idx[SYM_W-1:1];
    sel_bits    = SEL_N'({tail_r, frame_r});
    phys_bit    = sel_bits[logical_idx[KW-1:0]] ^ phys_idx[0];
    if (sym_r == '0) begin
      low_units = SYNC_LOW_UNITS;
    end else if (sym_r > SYM_W'(NPHYS)) begin
      low_units = PAUSE_LOW_UNITS;
    end else begin
      low_units = phys_bit ? ONE_LOW_UNITS : ZERO_LOW_UNITS;
    end
  end

  assign period   = (cfg.ticks_per_unit == '0) ? PERIOD_W'(1) : cfg.ticks_per_unit;
  assign tick_sum = {1'b0, tick_r} + (PERIOD_W + 1)'(1);
  assign unit_inc = unit_r + UNIT_W'(1);
  assign id_ext   = 32'(cmd.tx_id);

  // step the sequencer for one command
  always_comb begin
    phase_nxt = phase_r;
    frame_nxt = frame_r;
    tail_nxt  = tail_r;
    sym_nxt   = sym_r;
    tick_nxt  = tick_r;
    unit_nxt  = unit_r;
    accepted  = 1'b0;
    done      = 1'b0;
    if (take) begin
      if (cmd.kind == CMD_START) begin
        if (phase_r == PH_IDLE) begin
          frame_nxt = id_ext[ID_BITS-1:0];
          tail_nxt  = {cfg.unit_bits[0], cfg.unit_bits[1],
                       cfg.channel_bits[0], cfg.channel_bits[1],
                       cmd.on_off, cfg.group_bit};
          phase_nxt = PH_HIGH;
          sym_nxt   = '0;
          tick_nxt  = '0;
          unit_nxt  = '0;
          accepted  = 1'b1;
        end
      end else if (phase_r != PH_IDLE) begin
        if (tick_sum >= {1'b0, period}) begin
          tick_nxt = '0;
          if (phase_r == PH_HIGH) begin
            phase_nxt = PH_LOW;
            unit_nxt  = '0;
          end else if (unit_inc >= low_units) begin
            unit_nxt = '0;
            if (sym_r > SYM_W'(NPHYS)) begin
              phase_nxt = PH_IDLE;
              sym_nxt   = '0;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_HIGH;
              sym_nxt   = sym_r + SYM_W'(1);
            end
          end else begin
            unit_nxt = unit_inc;
          end
        end else begin
          tick_nxt = tick_sum[PERIOD_W-1:0];
        end
      end
    end
  end

  // build the result and hold it until taken
  always_comb begin
    res_nxt            = res_r;
    res_valid_nxt      = res_valid_r;
    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end
    if (take) begin
      res_valid_nxt      = 1'b1;
      res_nxt.line_level = (phase_nxt == PH_HIGH);
      res_nxt.busy_res   = (phase_nxt != PH_IDLE);
      res_nxt.accepted   = accepted;
      res_nxt.frame_done = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      frame_r     <= '0;
      tail_r      <= '0;
      sym_r       <= '0;
      tick_r      <= '0;
      unit_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      frame_r     <= frame_nxt;
      tail_r      <= tail_nxt;
      sym_r       <= sym_nxt;
      tick_r      <= tick_nxt;
      unit_r      <= unit_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule : rfe_back

`default_nettype wire

// File: rtl/core/rf_remote_frame_encoder.sv
// ============================================================================
// rf_remote_frame_encoder - on-off keyed pulse-distance RF remote encoder
// Top level: configuration registers, command front end and frame sequencer.
// ============================================================================
// Each input transaction is either a start request (tuser = 0) carrying a
// transmitter id and an on/off bit, or one time tick (tuser = 1), and each
// gives exactly one result transaction with the line level, busy, accepted
// and frame-done flags after that item. A frame is a sync, the id LSB first
// followed by group, on/off, channel and unit bits, each sent as two
// pulse-distance symbols, and a closing pause; the base period T is
// ticks_per_unit ticks. While the result side does not stall, the block takes
// one transaction per clock: the front end queues up to two items, the
// sequencer steps one item per clock, and out_tvalid is registered, rising
// in the cycle after its item is taken. Back-pressure on the result side
// fills the queue before in_tready drops. Configuration writes are taken at
// any time (cfg_ready is always high) and belong in idle periods; group,
// channel and unit bits are sampled when a start is taken.
// ============================================================================
`default_nettype none

module rf_remote_frame_encoder #(
  parameter int ID_BITS = rfe_pkg::ID_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,  // [25:0] tx_id, [26] on_off
  input  wire logic [0:0]                    in_tuser,  // [0] mode
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata, // [0] line_level, [1] busy_res,
                                                        // [2] accepted, [3] frame_done
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rfe_pkg::PERIOD_W-1:0]  cfg_data
);

  import rfe_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  // configuration register file
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TICKS_PER_UNIT: cfg_nxt.ticks_per_unit = cfg_data;
        CFG_GROUP_BIT:      cfg_nxt.group_bit      = cfg_data[0];
        CFG_CHANNEL_BITS:   cfg_nxt.channel_bits   = cfg_data[1:0];
        CFG_UNIT_BITS:      cfg_nxt.unit_bits      = cfg_data[1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_unit <= TICKS_PER_UNIT_RST;
      cfg_r.group_bit      <= GROUP_BIT_RST;
      cfg_r.channel_bits   <= CHANNEL_BITS_RST;
      cfg_r.unit_bits      <= UNIT_BITS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // accept and classify
  rfe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_mode       (in_tuser[0]),
    .in_tx_id      (in_tdata[TX_ID_W-1:0]),
    .in_on_off     (in_tdata[TX_ID_W]),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  // sequence the frame
  rfe_back #(
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {4'b0000, res.frame_done, res.accepted, res.busy_res, res.line_level};

endmodule : rf_remote_frame_encoder

`default_nettype wire
